FILE: sv/edf_thread_scheduler_assert.svh
// assertion macros for the scheduler
`ifndef EDF_THREAD_SCHEDULER_ASSERT_SVH
`define EDF_THREAD_SCHEDULER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define EDFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EDFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/edfs_pkg.sv
package edfs_pkg;

	// table size and derived widths
	localparam int MAX_TASKS = 8;
	localparam int TIDX_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CUR_W     = TIDX_W + 1;
	localparam logic [CUR_W-1:0] IDLE_IDX = CUR_W'(MAX_TASKS);

	// fixed field widths
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 3;
	localparam int TICKS_W = 16;
	localparam int TIMER_W = 32;
	localparam int CNT_W   = 4;
	localparam int RUN_W   = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_YIELD  = 3'd1,
		CMD_SLEEP  = 3'd2,
		CMD_DEFINE = 3'd3,
		CMD_START  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_WAITING  = 2'd0,
		ST_SLEEPING = 2'd1,
		ST_ACTIVE   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CUR,
		S_DEF,
		S_TICK,
		S_FIN,
		S_PICK,
		S_SET,
		S_DONE
	} state_t;

	// one thread table entry as stored in memory
	typedef struct packed {
		status_t              status;
		logic [TIMER_W-1:0]   timer;
		logic [TICKS_W-1:0]   deadline;
		logic [TICKS_W-1:0]   period;
	} entry_t;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [IDX_W-1:0]   thread_index;
		logic [TICKS_W-1:0] deadline_ticks;
		logic [TICKS_W-1:0] period_ticks;
		logic [TICKS_W-1:0] sleep_ticks;
	} req_word_t;

	typedef struct packed {
		logic [RUN_W-1:0] running_thread;
		logic             switched;
		logic             deadline_missed;
	} rsp_word_t;

endpackage

FILE: sv/edfs_ram.sv
module edfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/edf_thread_scheduler.sv
// channel   dir   handshake             word
// cfg       in    cfg_wen               cfg_wdata (thread count)
// req       in    req_valid/req_stall   req_word (command)
// rsp       out   rsp_valid/rsp_stall   rsp_word (running thread, flags)
//
// tick sweeps the active threads to update their timers and, on a switch,
// sweeps them again to pick; yield and sleep only pick; others do not sweep.
// the table memory is swept one entry a cycle, for update and then for pick.
// reset is asynchronous; unwritten entries read as waiting with zero timer
// through per-entry valid bits, so no clearing pass is needed.
// req_stall is high while a command is in progress; a stalled response holds
// the block in its done state.
`include "edf_thread_scheduler_assert.svh"

module edf_thread_scheduler (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [edfs_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  edfs_pkg::req_word_t       req_word,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output edfs_pkg::rsp_word_t       rsp_word
);

	import edfs_pkg::*;

	// requeue a thread that gives up the processor
	function automatic entry_t requeue(input entry_t e);
		entry_t r;
		r = e;
		if (e.period != '0) begin
			r.status = ST_SLEEPING;
			r.timer  = TIMER_W'(e.period);
		end else begin
			r.status = ST_WAITING;
			r.timer  = TIMER_W'(e.deadline);
		end
		return r;
	endfunction

	// entries never written read as waiting with zero timer
	function automatic entry_t eff_entry(input logic vld, input entry_t raw);
		entry_t r;
		r = raw;
		if (!vld) begin
			r.status = ST_WAITING;
			r.timer  = '0;
		end
		return r;
	endfunction

	state_t             state_q, state_d;
	req_word_t          req_q, req_d;
	logic [CNT_W-1:0]   cnt_q;
	logic [CUR_W-1:0]   cur_q, cur_d;
	logic [MAX_TASKS-1:0] valid_q;
	logic [TIDX_W-1:0]  i_q, i_d;
	entry_t             creg_q, creg_d;
	logic               pre_q, pre_d;
	logic               leave_q, leave_d;
	logic               missed_q, missed_d;
	logic               sw_q, sw_d;
	logic               found_q, found_d;
	logic [TIDX_W-1:0]  best_q, best_d;
	entry_t             best_ent_q, best_ent_d;
	rsp_word_t          rsp_q;
	logic               rsp_valid_q;
	logic               rd_vld_s1;

	logic                    ram_we;
	logic [TIDX_W-1:0]       ram_waddr, ram_raddr;
	entry_t                  wr_ent;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t                  rd_ent;

	logic [CUR_W-1:0]   n_act;
	logic               last;
	logic               cur_real;
	logic [TIDX_W-1:0]  c_idx;
	logic               rsp_load;
	logic               c_expired;
	entry_t             e_mod;
	logic [TIMER_W-1:0] t_dec;
	logic [TIMER_W-1:0] tc_eff;

	edfs_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_TASKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_ent),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// derived control values
	assign n_act    = (int'(cnt_q) > MAX_TASKS) ? CUR_W'(MAX_TASKS) : CUR_W'(cnt_q);
	assign last     = (({1'b0, i_q} + 1'b1) == n_act);
	assign cur_real = (int'(cur_q) < MAX_TASKS);
	assign c_idx    = cur_q[TIDX_W-1:0];
	assign rd_ent   = eff_entry(rd_vld_s1, entry_t'(ram_rdata));
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign c_expired = cur_real && ($signed(creg_q.timer) <= 0);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, table access and working values
	always_comb begin
		state_d    = state_q;
		req_d      = req_q;
		cur_d      = cur_q;
		i_d        = i_q;
		creg_d     = creg_q;
		pre_d      = pre_q;
		leave_d    = leave_q;
		missed_d   = missed_q;
		sw_d       = sw_q;
		found_d    = found_q;
		best_d     = best_q;
		best_ent_d = best_ent_q;
		ram_we     = 1'b0;
		ram_waddr  = i_q;
		ram_raddr  = '0;
		wr_ent     = rd_ent;
		e_mod      = rd_ent;
		t_dec      = rd_ent.timer - 1'b1;
		tc_eff     = creg_q.timer;

		unique case (state_q)
			S_IDLE: begin
				ram_raddr = (req_word.cmd == CMD_START) ? '0 : c_idx;
				if (req_valid) begin
					req_d    = req_word;
					sw_d     = 1'b0;
					missed_d = 1'b0;
					pre_d    = 1'b0;
					leave_d  = 1'b0;
					found_d  = 1'b0;
					i_d      = '0;
					unique case (req_word.cmd)
						CMD_TICK, CMD_YIELD, CMD_SLEEP, CMD_START: state_d = S_CUR;
						CMD_DEFINE: state_d = S_DEF;
						default: state_d = S_DONE;
					endcase
				end
			end

			S_DEF: begin
				if (int'(req_q.thread_index) < MAX_TASKS) begin
					ram_we          = 1'b1;
					ram_waddr       = TIDX_W'(req_q.thread_index);
					wr_ent.status   = ST_WAITING;
					wr_ent.timer    = TIMER_W'(req_q.deadline_ticks);
					wr_ent.deadline = req_q.deadline_ticks;
					wr_ent.period   = req_q.period_ticks;
				end
				state_d = S_DONE;
			end

			// running thread entry (entry 0 on start) has arrived
			S_CUR: begin
				creg_d = rd_ent;
				unique case (req_q.cmd)
					CMD_START: begin
						sw_d = 1'b1;
						if (n_act != '0) begin
							cur_d         = '0;
							ram_we        = 1'b1;
							ram_waddr     = '0;
							wr_ent.status = ST_ACTIVE;
						end else begin
							cur_d = IDLE_IDX;
						end
						state_d = S_DONE;
					end
					CMD_TICK: begin
						state_d = (n_act == '0) ? S_FIN : S_TICK;
					end
					CMD_YIELD, CMD_SLEEP: begin
						sw_d = 1'b1;
						if (req_q.cmd == CMD_SLEEP) begin
							e_mod.status = ST_SLEEPING;
							e_mod.timer  = TIMER_W'(req_q.sleep_ticks);
						end
						if (e_mod.period != '0 || e_mod.status != ST_SLEEPING) begin
							e_mod = requeue(e_mod);
						end
						if (cur_real) begin
							ram_we    = 1'b1;
							ram_waddr = c_idx;
							wr_ent    = e_mod;
							creg_d    = e_mod;
						end
						state_d = (n_act == '0) ? S_SET : S_PICK;
					end
					default: state_d = S_DONE;
				endcase
			end

			// timer update sweep, entry i_q
			S_TICK: begin
				e_mod       = rd_ent;
				e_mod.timer = t_dec;
				if (!($signed(t_dec) > 0)) begin
					if (rd_ent.status == ST_WAITING) begin
						missed_d = 1'b1;
					end
					if (rd_ent.status == ST_SLEEPING) begin
						e_mod.status = ST_WAITING;
						e_mod.timer  = TIMER_W'(rd_ent.deadline);
						if (!cur_real) begin
							leave_d = 1'b1;
						end else begin
							tc_eff = (i_q == c_idx) ? e_mod.timer : creg_q.timer;
							if ($signed(e_mod.timer) < $signed(tc_eff) ||
							    (e_mod.timer == tc_eff && i_q < c_idx)) begin
								pre_d = 1'b1;
							end
						end
					end
				end
				ram_we    = 1'b1;
				ram_waddr = i_q;
				wr_ent    = e_mod;
				if (cur_real && i_q == c_idx) begin
					creg_d = e_mod;
				end
				ram_raddr = i_q + 1'b1;
				i_d       = i_q + 1'b1;
				if (last) begin
					state_d = S_FIN;
				end
			end

			// decide on rescheduling after the sweep
			S_FIN: begin
				i_d = '0;
				if (pre_q || leave_q || c_expired) begin
					sw_d = 1'b1;
					if (pre_q) begin
						e_mod        = creg_q;
						e_mod.status = ST_WAITING;
					end else begin
						e_mod = requeue(creg_q);
					end
					if (cur_real) begin
						ram_we    = 1'b1;
						ram_waddr = c_idx;
						wr_ent    = e_mod;
						creg_d    = e_mod;
					end
					state_d = (n_act == '0) ? S_SET : S_PICK;
				end else begin
					state_d = S_DONE;
				end
			end

			// minimum search sweep; the running entry comes from its register
			S_PICK: begin
				e_mod = (cur_real && i_q == c_idx) ? creg_q : rd_ent;
				if (e_mod.status == ST_WAITING &&
				    (!found_q || $signed(e_mod.timer) < $signed(best_ent_q.timer))) begin
					found_d    = 1'b1;
					best_d     = i_q;
					best_ent_d = e_mod;
				end
				ram_raddr = i_q + 1'b1;
				i_d       = i_q + 1'b1;
				if (last) begin
					state_d = S_SET;
				end
			end

			S_SET: begin
				if (found_q) begin
					cur_d         = {1'b0, best_q};
					ram_we        = 1'b1;
					ram_waddr     = best_q;
					wr_ent        = best_ent_q;
					wr_ent.status = ST_ACTIVE;
				end else begin
					cur_d = IDLE_IDX;
				end
				state_d = S_DONE;
			end

			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cur_q       <= IDLE_IDX;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cnt_q <= cfg_wdata;
			end
			cur_q <= cur_d;
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working and payload registers
	always_ff @(posedge clk) begin
		req_q      <= req_d;
		i_q        <= i_d;
		creg_q     <= creg_d;
		pre_q      <= pre_d;
		leave_q    <= leave_d;
		missed_q   <= missed_d;
		sw_q       <= sw_d;
		found_q    <= found_d;
		best_q     <= best_d;
		best_ent_q <= best_ent_d;
		rd_vld_s1  <= valid_q[ram_raddr];
		if (rsp_load) begin
			rsp_q.running_thread  <= RUN_W'(cur_q);
			rsp_q.switched        <= sw_q;
			rsp_q.deadline_missed <= missed_q;
		end
	end

	// checks
	`EDFS_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_q != S_IDLE,
		"accepted word did not start processing")
	`EDFS_ASSERT_NOW(a_missed_only_tick, rsp_load && missed_q, req_q.cmd == CMD_TICK,
		"missed deadline flagged on a command other than tick")
	`EDFS_ASSERT_NOW(a_cur_in_range, state_q == S_DONE, int'(cur_q) <= MAX_TASKS,
		"running thread index out of range")
	`EDFS_ASSERT_NOW(a_pick_waiting, state_q == S_SET && found_q,
		best_ent_q.status == ST_WAITING, "picked thread was not waiting")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import edfs_pkg::*;

	localparam int HANG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 2 * MAX_TASKS + 8;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 215;
	localparam int MAX_PRINTS = 100;

	// command codes the block must ignore
	localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

	typedef struct {
		bit                is_cfg;
		logic [CNT_W-1:0]  cfg_val;
		req_word_t         word;
		bit                typed;
		rsp_word_t         want;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic [CNT_W-1:0]  cfg_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_word_t         req_word = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_word_t         rsp_word;

	// thread table as the scheduler should hold it
	status_t           thr_status[MAX_TASKS];
	logic [31:0]       thr_timer[MAX_TASKS];
	logic [15:0]       thr_deadline[MAX_TASKS];
	logic [15:0]       thr_period[MAX_TASKS];
	int                run_thread;
	logic [CNT_W-1:0]  sched_count;

	rsp_word_t         sched_outcomes[$];
	row_t              dir_rows[$];
	int                send_pct = 0;
	int                recv_pct = 0;
	int                mismatch_count = 0;
	int                result_idx = 0;
	int                idle_cycles = 0;
	int                phase_count[PHASES] = '{8, 3, 0, 12, 1, 8, 5, 2};

	edf_thread_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	always #10 clk = ~clk;

	function automatic int live_count();
		return (sched_count > MAX_TASKS) ? MAX_TASKS : int'(sched_count);
	endfunction

	// running thread gives up the processor
	function automatic void requeue_running();
		if (run_thread < MAX_TASKS) begin
			if (thr_period[run_thread] != 16'd0) begin
				thr_status[run_thread] = ST_SLEEPING;
				thr_timer[run_thread] = {16'd0, thr_period[run_thread]};
			end else begin
				thr_status[run_thread] = ST_WAITING;
				thr_timer[run_thread] = {16'd0, thr_deadline[run_thread]};
			end
		end
	endfunction

	// earliest timer among waiting threads, lowest index on ties
	function automatic void pick_earliest();
		int best;
		bit found;
		best = 0;
		found = 1'b0;
		for (int i = 0; i < live_count(); i++) begin
			if (thr_status[i] != ST_WAITING)
				continue;
			if (!found || $signed(thr_timer[i]) < $signed(thr_timer[best])) begin
				best = i;
				found = 1'b1;
			end
		end
		run_thread = found ? best : MAX_TASKS;
		if (run_thread < MAX_TASKS)
			thr_status[run_thread] = ST_ACTIVE;
	endfunction

	// advance the table by one command word and return the outcome
	function automatic rsp_word_t edf_step(req_word_t w);
		rsp_word_t r;
		int c;
		bit pre;
		bit leave;
		bit sw;
		bit missed;
		c = run_thread;
		pre = 1'b0;
		leave = 1'b0;
		sw = 1'b0;
		missed = 1'b0;
		case (w.cmd)
			CMD_TICK: begin
				for (int i = 0; i < live_count(); i++) begin
					thr_timer[i] = thr_timer[i] - 32'd1;
					if ($signed(thr_timer[i]) > 0)
						continue;
					if (thr_status[i] == ST_WAITING)
						missed = 1'b1;
					if (thr_status[i] == ST_SLEEPING) begin
						thr_status[i] = ST_WAITING;
						thr_timer[i] = {16'd0, thr_deadline[i]};
						if (c >= MAX_TASKS) begin
							leave = 1'b1;
						end else if ($signed(thr_timer[i]) < $signed(thr_timer[c]) ||
							(thr_timer[i] == thr_timer[c] && i < c)) begin
							pre = 1'b1;
						end
					end
				end
				if (pre || leave || (c < MAX_TASKS && $signed(thr_timer[c]) <= 0)) begin
					if (pre)
						thr_status[c] = ST_WAITING;
					else
						requeue_running();
					pick_earliest();
					sw = 1'b1;
				end
			end
			CMD_YIELD, CMD_SLEEP: begin
				if (c < MAX_TASKS) begin
					if (w.cmd == CMD_SLEEP) begin
						thr_status[c] = ST_SLEEPING;
						thr_timer[c] = {16'd0, w.sleep_ticks};
					end
					if (thr_period[c] != 16'd0 || thr_status[c] != ST_SLEEPING)
						requeue_running();
				end
				pick_earliest();
				sw = 1'b1;
			end
			CMD_DEFINE: begin
				thr_status[w.thread_index] = ST_WAITING;
				thr_deadline[w.thread_index] = w.deadline_ticks;
				thr_period[w.thread_index] = w.period_ticks;
				thr_timer[w.thread_index] = {16'd0, w.deadline_ticks};
			end
			CMD_START: begin
				if (live_count() > 0) begin
					run_thread = 0;
					thr_status[0] = ST_ACTIVE;
				end else begin
					run_thread = MAX_TASKS;
				end
				sw = 1'b1;
			end
			default: ;
		endcase
		r.running_thread = RUN_W'(run_thread);
		r.switched = sw;
		r.deadline_missed = missed;
		return r;
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("mismatch on %s at result %0d: expected %0d, got %0d",
				what, result_idx, want, got);
	endtask

	function automatic void add_word(logic [CMD_W-1:0] cmd, int idx, int dl, int per,
		int slp, bit typed, int run, bit sw, bit miss);
		row_t r;
		r.is_cfg = 1'b0;
		r.cfg_val = '0;
		r.word.cmd = cmd;
		r.word.thread_index = IDX_W'(idx);
		r.word.deadline_ticks = TICKS_W'(dl);
		r.word.period_ticks = TICKS_W'(per);
		r.word.sleep_ticks = TICKS_W'(slp);
		r.typed = typed;
		r.want.running_thread = RUN_W'(run);
		r.want.switched = sw;
		r.want.deadline_missed = miss;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_cfg(int v);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.cfg_val = CNT_W'(v);
		dir_rows.push_back(r);
	endfunction

	function automatic logic [CMD_W-1:0] CMD_LOGIC_RSVD();
		return CMD_W'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
	endfunction

	// random command word, mostly small timing values so threads expire often
	function automatic req_word_t rand_word();
		req_word_t w;
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			w.cmd = CMD_TICK;
		else if (pick < 55)
			w.cmd = CMD_YIELD;
		else if (pick < 68)
			w.cmd = CMD_SLEEP;
		else if (pick < 85)
			w.cmd = CMD_DEFINE;
		else if (pick < 90)
			w.cmd = CMD_START;
		else
			w.cmd = CMD_LOGIC_RSVD();
		w.thread_index = IDX_W'($urandom_range(MAX_TASKS - 1));
		if ($urandom_range(9) == 0)
			w.deadline_ticks = TICKS_W'($urandom_range(1, 65535));
		else
			w.deadline_ticks = TICKS_W'($urandom_range(1, 12));
		pick = $urandom_range(9);
		if (pick < 4)
			w.period_ticks = '0;
		else if (pick < 9)
			w.period_ticks = TICKS_W'($urandom_range(1, 12));
		else
			w.period_ticks = TICKS_W'($urandom_range(65535));
		if ($urandom_range(99) < 85)
			w.sleep_ticks = TICKS_W'($urandom_range(10));
		else
			w.sleep_ticks = TICKS_W'($urandom_range(65535));
		return w;
	endfunction

	// offer one word, with optional gap or full drain, and log its outcome
	task automatic send_word(req_word_t w, bit typed, rsp_word_t want);
		rsp_word_t got;
		bit hold;
		bit gap;
		hold = (send_pct != 0) && ($urandom_range(99) == 0);
		gap = (send_pct != 0) && ($urandom_range(99) < send_pct);
		if (hold || gap) begin
			req_valid <= 1'b0;
			if (hold) begin
				while (sched_outcomes.size() != 0)
					@(posedge clk);
			end
			do
				@(posedge clk);
			while ($urandom_range(99) < send_pct);
		end
		req_valid <= 1'b1;
		req_word <= w;
		do
			@(posedge clk);
		while (req_stall);
		got = edf_step(w);
		sched_outcomes.push_back(typed ? want : got);
	endtask

	// block idle: nothing pending and the last command fully retired
	task automatic settle();
		req_valid <= 1'b0;
		while (sched_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [CNT_W-1:0] v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sched_count = v;
	endtask

	// result check and receiver stall
	always @(posedge clk) begin : rsp_check
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (sched_outcomes.size() == 0) begin
				report_mismatch("result with nothing pending", 0, 0);
			end else begin
				want = sched_outcomes.pop_front();
				if (rsp_word.running_thread !== want.running_thread)
					report_mismatch("running_thread", want.running_thread,
						rsp_word.running_thread);
				if (rsp_word.switched !== want.switched)
					report_mismatch("switched", want.switched, rsp_word.switched);
				if (rsp_word.deadline_missed !== want.deadline_missed)
					report_mismatch("deadline_missed", want.deadline_missed,
						rsp_word.deadline_missed);
			end
			result_idx++;
		end
		rsp_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
	end

	// cycles since the last word moved on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < HANG_LIMIT)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int made;
		req_word_t w;
		for (int i = 0; i < MAX_TASKS; i++) begin
			thr_status[i] = ST_WAITING;
			thr_timer[i] = '0;
			thr_deadline[i] = '0;
			thr_period[i] = '0;
		end
		run_thread = MAX_TASKS;
		sched_count = '0;

		// no threads counted yet: every command lands on the idle thread
		add_word(CMD_RSVD_C, 7, 65535, 65535, 65535, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_word(CMD_START, 0, 1, 0, 0, 1'b1, IDLE_IDX, 1'b1, 1'b0);
		add_word(CMD_YIELD, 0, 1, 0, 0, 1'b1, IDLE_IDX, 1'b1, 1'b0);
		add_word(CMD_TICK, 0, 1, 0, 0, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_cfg(MAX_TASKS);
		// fill the whole table, field extremes included
		add_word(CMD_DEFINE, 0, 3, 0, 0, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_word(CMD_DEFINE, 1, 65535, 65535, 0, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_word(CMD_DEFINE, 2, 1, 0, 0, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_word(CMD_DEFINE, 3, 5, 4, 0, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_word(CMD_DEFINE, 4, 2, 0, 0, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_word(CMD_DEFINE, 5, 7, 0, 0, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_word(CMD_DEFINE, 6, 4, 2, 0, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_word(CMD_DEFINE, 7, 9, 0, 0, 1'b1, IDLE_IDX, 1'b0, 1'b0);
		add_word(CMD_START, 0, 1, 0, 0, 1'b1, 0, 1'b1, 1'b0);
		// expiry, wake with preemption, sleep extremes, ignored codes
		add_word(CMD_TICK, 0, 1, 0, 0, 1'b0, 0, 1'b0, 1'b0);
		add_word(CMD_YIELD, 0, 1, 0, 0, 1'b0, 0, 1'b0, 1'b0);
		add_word(CMD_SLEEP, 0, 1, 0, 0, 1'b0, 0, 1'b0, 1'b0);
		add_word(CMD_TICK, 0, 1, 0, 0, 1'b0, 0, 1'b0, 1'b0);
		add_word(CMD_TICK, 0, 1, 0, 0, 1'b0, 0, 1'b0, 1'b0);
		add_word(CMD_SLEEP, 0, 1, 0, 65535, 1'b0, 0, 1'b0, 1'b0);
		add_word(CMD_YIELD, 0, 1, 0, 0, 1'b0, 0, 1'b0, 1'b0);
		add_word(CMD_RSVD_A, 0, 1, 0, 0, 1'b0, 0, 1'b0, 1'b0);
		add_word(CMD_RSVD_B, 0, 1, 0, 0, 1'b0, 0, 1'b0, 1'b0);
		add_word(CMD_TICK, 0, 1, 0, 0, 1'b0, 0, 1'b0, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_cfg) begin
				settle();
				write_count(dir_rows[k].cfg_val);
			end else begin
				send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
			end
		end

		// random phases over thread counts and idle patterns
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_count(CNT_W'(phase_count[p]));
			case (p % 4)
				0: begin
					send_pct = 0;
					recv_pct = 0;
				end
				1: begin
					send_pct = 52;
					recv_pct = 0;
				end
				2: begin
					send_pct = 0;
					recv_pct = 52;
				end
				default: begin
					send_pct = 13;
					recv_pct = 13;
				end
			endcase
			made = 0;
			while (made < WORDS_PER_PHASE) begin
				w = rand_word();
				send_word(w, 1'b0, '0);
				made++;
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/edfs_pkg.sv
sv/edfs_ram.sv
sv/edf_thread_scheduler.sv
tb/sv/tb.sv
